@@ rtl/core/cptg_pkg.sv @@
`timescale 1ns / 1ps

package cptg_pkg;

    localparam int PH_W    = 24;
    localparam int SCALE_W = 18;
    localparam int ACC_W   = 32;
    localparam int SMP_W   = 32;
    localparam int OP_W    = 27;
    localparam int PROD_W  = 54;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    localparam logic [1:0] REG_RATE_REAL  = 2'd0;
    localparam logic [1:0] REG_RATE_IMAG  = 2'd1;
    localparam logic [1:0] REG_START_REAL = 2'd2;
    localparam logic [1:0] REG_START_IMAG = 2'd3;

    localparam logic signed [PH_W-1:0] ONE_Q22 = 24'sd4194304;
    localparam logic signed [PH_W-1:0] ZERO_PH = 24'sd0;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic                      restart;
        logic signed [SCALE_W-1:0] scale;
        logic signed [ACC_W-1:0]   acc_real;
        logic signed [ACC_W-1:0]   acc_imag;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

@@ rtl/core/cptg_front.sv @@
`timescale 1ns / 1ps

module cptg_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cptg_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output cptg_pkg::q_head_t                   head,
    input  logic                                pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cptg_pkg::cmd_t   queue_reg [QUEUE_DEPTH];
    cptg_pkg::cmd_t   in_cmd;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             do_pop;

    // Sort the beat into a command: tuser carries the kind, tdata the operands.
    always_comb begin
        in_cmd.restart  = s_tuser;
        in_cmd.scale    = s_tdata[17:0];
        in_cmd.acc_real = s_tdata[49:18];
        in_cmd.acc_imag = s_tdata[81:50];
    end

    assign s_tready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/cptg_back.sv @@
`timescale 1ns / 1ps

module cptg_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cptg_pkg::q_head_t                   head,
    output logic                                pop,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [cptg_pkg::PH_W-1:0]           cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cptg_pkg::M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OUT,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_MAG,
        ST_NORM,
        ST_FIN
    } state_t;

    localparam int PW = cptg_pkg::PROD_W;

    state_t                                   state_reg;
    logic signed [cptg_pkg::PH_W-1:0]         rate_re_reg, rate_im_reg;
    logic signed [cptg_pkg::PH_W-1:0]         start_re_reg, start_im_reg;
    logic signed [cptg_pkg::PH_W-1:0]         ph_re_reg, ph_im_reg;
    logic signed [cptg_pkg::PH_W-1:0]         rot_re_reg, rot_im_reg;
    logic signed [cptg_pkg::OP_W-1:0]         f_reg;
    logic signed [cptg_pkg::SCALE_W-1:0]      scale_reg;
    logic signed [cptg_pkg::ACC_W-1:0]        acc_re_reg, acc_im_reg;
    logic signed [PW-1:0]                     prod_a_reg, prod_b_reg;
    logic signed [cptg_pkg::OP_W-1:0]         op_a1, op_a2, op_b1, op_b2;
    logic signed [PW-1:0]                     mul_a, mul_b;
    logic                                     out_valid_reg;
    logic [cptg_pkg::M_TDATA_W-1:0]           out_data_reg;
    logic                                     out_free;
    logic                                     prod_en;
    logic signed [PW-1:0]                     smp_re, smp_im;
    logic signed [PW-1:0]                     mag;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int s);
        logic signed [PW-1:0] half;
        half = PW'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [cptg_pkg::PH_W-1:0] sat_ph(input logic signed [PW-1:0] v);
        if (v > PW'(signed'(24'sh7FFFFF))) begin
            return 24'sh7FFFFF;
        end else if (v < PW'(signed'(24'sh800000))) begin
            return 24'sh800000;
        end
        return v[cptg_pkg::PH_W-1:0];
    endfunction

    function automatic logic signed [cptg_pkg::SMP_W-1:0] sat_smp(input logic signed [PW-1:0] v);
        if (v > PW'(signed'(32'sh7FFFFFFF))) begin
            return 32'sh7FFFFFFF;
        end else if (v < PW'(signed'(32'sh80000000))) begin
            return 32'sh80000000;
        end
        return v[cptg_pkg::SMP_W-1:0];
    endfunction

    function automatic logic signed [cptg_pkg::OP_W-1:0] ext_ph(
        input logic signed [cptg_pkg::PH_W-1:0] v
    );
        return cptg_pkg::OP_W'(v);
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign prod_en  = (state_reg != ST_OUT) || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Operand selection for the shared pair of multipliers.
    always_comb begin
        op_a1 = '0;
        op_a2 = '0;
        op_b1 = '0;
        op_b2 = '0;
        unique case (state_reg)
            ST_SCALE: begin
                op_a1 = ext_ph(ph_re_reg);
                op_a2 = cptg_pkg::OP_W'(scale_reg);
                op_b1 = ext_ph(ph_im_reg);
                op_b2 = cptg_pkg::OP_W'(scale_reg);
            end
            ST_OUT: begin
                op_a1 = ext_ph(ph_re_reg);
                op_a2 = ext_ph(rate_re_reg);
                op_b1 = ext_ph(ph_im_reg);
                op_b2 = ext_ph(rate_im_reg);
            end
            ST_ROT_A: begin
                op_a1 = ext_ph(ph_re_reg);
                op_a2 = ext_ph(rate_im_reg);
                op_b1 = ext_ph(ph_im_reg);
                op_b2 = ext_ph(rate_re_reg);
            end
            ST_ROT_C: begin
                op_a1 = ext_ph(rot_re_reg);
                op_a2 = ext_ph(rot_re_reg);
                op_b1 = ext_ph(rot_im_reg);
                op_b2 = ext_ph(rot_im_reg);
            end
            ST_NORM: begin
                op_a1 = ext_ph(rot_re_reg);
                op_a2 = f_reg;
                op_b1 = ext_ph(rot_im_reg);
                op_b2 = f_reg;
            end
            default: begin
                op_a1 = '0;
            end
        endcase
    end

    assign mul_a  = op_a1 * op_a2;
    assign mul_b  = op_b1 * op_b2;
    assign smp_re = PW'(acc_re_reg) + rnd(prod_a_reg, 14);
    assign smp_im = PW'(acc_im_reg) + rnd(prod_b_reg, 14);
    assign mag    = rnd(prod_a_reg + prod_b_reg, 22);

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_a_reg <= mul_a;
            prod_b_reg <= mul_b;
        end
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rate_re_reg   <= cptg_pkg::ONE_Q22;
            rate_im_reg   <= cptg_pkg::ZERO_PH;
            start_re_reg  <= cptg_pkg::ONE_Q22;
            start_im_reg  <= cptg_pkg::ZERO_PH;
            ph_re_reg     <= cptg_pkg::ONE_Q22;
            ph_im_reg     <= cptg_pkg::ZERO_PH;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cptg_pkg::REG_RATE_REAL:  rate_re_reg  <= cfg_wdata;
                    cptg_pkg::REG_RATE_IMAG:  rate_im_reg  <= cfg_wdata;
                    cptg_pkg::REG_START_REAL: start_re_reg <= cfg_wdata;
                    cptg_pkg::REG_START_IMAG: start_im_reg <= cfg_wdata;
                    default:                  rate_re_reg  <= rate_re_reg;
                endcase
            end
            // In ST_OUT the output register is either refilled or still stalled.
            if (m_tready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (head.valid) begin
                        if (head.cmd.restart) begin
                            ph_re_reg <= start_re_reg;
                            ph_im_reg <= start_im_reg;
                        end else begin
                            scale_reg  <= head.cmd.scale;
                            acc_re_reg <= head.cmd.acc_real;
                            acc_im_reg <= head.cmd.acc_imag;
                            state_reg  <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // The sample waits here until the output register can take it.
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {sat_smp(smp_im), sat_smp(smp_re)};
                        state_reg     <= ST_ROT_A;
                    end
                end
                ST_ROT_A: begin
                    rot_re_reg <= sat_ph(rnd(prod_a_reg - prod_b_reg, 22));
                    state_reg  <= ST_ROT_B;
                end
                ST_ROT_B: begin
                    rot_im_reg <= sat_ph(rnd(prod_a_reg + prod_b_reg, 22));
                    state_reg  <= ST_ROT_C;
                end
                ST_ROT_C: begin
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    // Newton factor (3 - |p|^2) / 2, held as Q.23.
                    f_reg     <= cptg_pkg::OP_W'(PW'(3) * PW'(cptg_pkg::ONE_Q22) - mag);
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    ph_re_reg <= sat_ph(rnd(prod_a_reg, 23));
                    ph_im_reg <= sat_ph(rnd(prod_b_reg, 23));
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/complex_phasor_tone_generator.sv @@
`timescale 1ns / 1ps
// A sample beat taken into an empty queue is popped in ST_IDLE, scaled in ST_SCALE and put on
// m_tvalid from ST_OUT, which waits while the output is stalled; a restart item is done in ST_IDLE.
// Each sample's phasor update (rotation, magnitude and Newton step) then runs through one shared
// pair of multipliers before the next item is taken. The input queue holds up to QUEUE_DEPTH
// commands, so the front keeps accepting while the back works. Reset (aresetn low, synchronous)
// empties the queue and output, sets rate and start to 1.0 + 0j and loads the phasor with 1.0 + 0j.

module complex_phasor_tone_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // scale[17:0], acc_real[49:18], acc_imag[81:50], zero padding [87:82]
    input  logic [cptg_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_real[31:0], sample_imag[63:32]
    output logic [cptg_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [cptg_pkg::PH_W-1:0]           cfg_wdata
);

    cptg_pkg::q_head_t head;
    logic              pop;

    cptg_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    cptg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // The back end only takes a command that the queue actually holds.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head.valid)
        else $error("command popped from an empty queue");

    // A restart command never produces an output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.cmd.restart) |=> !$rose(m_tvalid))
        else $error("restart command produced a result");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

@@ sim/tb_complex_phasor_tone_generator.sv @@
`timescale 1ns / 1ps

module tb_complex_phasor_tone_generator;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TONE_PHASES   = 12;
    localparam int BEATS_PER_TONE = 110;

    localparam longint PH_HI  = 64'sd8388607;
    localparam longint PH_LO  = -64'sd8388608;
    localparam longint SMP_HI = 64'sd2147483647;
    localparam longint SMP_LO = -64'sd2147483648;

    localparam logic signed [cptg_pkg::PH_W-1:0] PH_MAX_V = 24'sh7FFFFF;
    localparam logic signed [cptg_pkg::PH_W-1:0] PH_MIN_V = 24'sh800000;

    typedef struct packed {
        logic signed [cptg_pkg::SMP_W-1:0] im;
        logic signed [cptg_pkg::SMP_W-1:0] re;
    } tone_sample_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    // scale[17:0], acc_real[49:18], acc_imag[81:50], zero padding [87:82]
    logic [cptg_pkg::S_TDATA_W-1:0]   s_tdata;
    // kind[0]
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    // sample_real[31:0], sample_imag[63:32]
    logic [cptg_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_we;
    logic [1:0]                       cfg_index;
    logic [cptg_pkg::PH_W-1:0]        cfg_wdata;

    // Mirror of the generator: rate, start and the running phasor, all Q2.22.
    longint rate_re, rate_im, start_re, start_im;
    longint ph_re, ph_im;

    tone_sample_t expected_samples[$];
    tone_sample_t want_sample, got_sample;
    int           errors = 0;
    int           cycles = 0;
    bit           no_gaps = 1'b0;

    complex_phasor_tone_generator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Rounding is add half, then floor; the arithmetic shift gives the floor.
    function automatic longint round_down(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic tone_sample_t mix_sample(input longint scale, input longint acc_re,
                                                input longint acc_im);
        tone_sample_t s;
        s.re = cptg_pkg::SMP_W'(clamp(acc_re + round_down(ph_re * scale, 14),
                                      SMP_LO, SMP_HI));
        s.im = cptg_pkg::SMP_W'(clamp(acc_im + round_down(ph_im * scale, 14),
                                      SMP_LO, SMP_HI));
        return s;
    endfunction

    // Rotate by the rate, then one Newton step towards unit magnitude.
    function automatic void rotate_phasor();
        longint re, im, mag, gain;
        re = clamp(round_down(ph_re * rate_re - ph_im * rate_im, 22), PH_LO, PH_HI);
        im = clamp(round_down(ph_re * rate_im + ph_im * rate_re, 22), PH_LO, PH_HI);
        mag = round_down(re * re + im * im, 22);
        gain = 3 * 64'sd4194304 - mag;
        ph_re = clamp(round_down(re * gain, 23), PH_LO, PH_HI);
        ph_im = clamp(round_down(im * gain, 23), PH_LO, PH_HI);
    endfunction

    task automatic send_item(input logic kind,
                             input logic signed [cptg_pkg::SCALE_W-1:0] scale,
                             input logic signed [cptg_pkg::ACC_W-1:0] acc_re,
                             input logic signed [cptg_pkg::ACC_W-1:0] acc_im);
        if (!no_gaps && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (!no_gaps && $urandom_range(99) < 19) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, acc_im, acc_re, scale};
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_RESTART) begin
            ph_re = start_re;
            ph_im = start_im;
        end else begin
            expected_samples.push_back(mix_sample(longint'(scale), longint'(acc_re),
                                                  longint'(acc_im)));
            rotate_phasor();
        end
    endtask

    // Leaves the stream idle with every result in and the phasor update finished.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index,
                             input logic signed [cptg_pkg::PH_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            cptg_pkg::REG_RATE_REAL:  rate_re  = longint'(value);
            cptg_pkg::REG_RATE_IMAG:  rate_im  = longint'(value);
            cptg_pkg::REG_START_REAL: start_re = longint'(value);
            cptg_pkg::REG_START_IMAG: start_im = longint'(value);
            default: ;
        endcase
    endtask

    task automatic program_tone(input logic signed [cptg_pkg::PH_W-1:0] rr,
                                input logic signed [cptg_pkg::PH_W-1:0] ri,
                                input logic signed [cptg_pkg::PH_W-1:0] sr,
                                input logic signed [cptg_pkg::PH_W-1:0] si);
        write_reg(cptg_pkg::REG_RATE_REAL, rr);
        write_reg(cptg_pkg::REG_RATE_IMAG, ri);
        write_reg(cptg_pkg::REG_START_REAL, sr);
        write_reg(cptg_pkg::REG_START_IMAG, si);
        cfg_we <= 1'b0;
    endtask

    // Out of reset the phasor is one and the rate is one, so the phasor stays put.
    task automatic test_sample_extremes();
        send_item(KIND_SAMPLE, 18'sd16384, 32'sd0, 32'sd0);
        send_item(KIND_SAMPLE, 18'sh1FFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_item(KIND_SAMPLE, 18'sh20000, 32'sh80000000, 32'sh80000000);
        send_item(KIND_SAMPLE, 18'sd0, 32'sd123, -32'sd456);
        send_item(KIND_SAMPLE, -18'sd1, 32'sd0, 32'sd0);
        send_item(KIND_RESTART, 18'sh1FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(KIND_SAMPLE, 18'sd16384, -32'sd4194304, 32'sd4194304);
        drain_and_settle();
    endtask

    task automatic test_quarter_turn();
        program_tone(24'sd0, 24'sd4194304, 24'sd0, -24'sd4194304);
        send_item(KIND_RESTART, 18'sd0, 32'sd0, 32'sd0);
        repeat (4) send_item(KIND_SAMPLE, 18'sd16384, 32'sd0, 32'sd0);
        send_item(KIND_RESTART, 18'sd0, 32'sd0, 32'sd0);
        send_item(KIND_SAMPLE, 18'sd8192, 32'sd1000, -32'sd1000);
        drain_and_settle();
    endtask

    // A phasor far from unit magnitude: the Newton step diverges and saturates.
    task automatic test_runaway_phasor();
        program_tone(PH_MAX_V, PH_MAX_V, PH_MIN_V, PH_MAX_V);
        send_item(KIND_RESTART, 18'sd0, 32'sd0, 32'sd0);
        repeat (3) send_item(KIND_SAMPLE, 18'sh1FFFF, 32'sd0, 32'sd0);
        drain_and_settle();
        program_tone(PH_MIN_V, PH_MIN_V, PH_MAX_V, PH_MIN_V);
        send_item(KIND_RESTART, 18'sd0, 32'sd0, 32'sd0);
        repeat (3) send_item(KIND_SAMPLE, 18'sh20000, 32'sd0, 32'sd0);
        drain_and_settle();
    endtask

    function automatic logic signed [cptg_pkg::PH_W-1:0] pick_extreme();
        case ($urandom_range(4))
            0: return PH_MAX_V;
            1: return PH_MIN_V;
            2: return 24'sd0;
            3: return 24'sd4194304;
            default: return -24'sd4194304;
        endcase
    endfunction

    task automatic test_random_tones();
        logic signed [cptg_pkg::PH_W-1:0]    rr, ri, sr, si;
        logic signed [cptg_pkg::SCALE_W-1:0] scale;
        logic signed [cptg_pkg::ACC_W-1:0]   acc_re, acc_im;
        real                                 ang, mag;
        for (int phase = 0; phase < TONE_PHASES; phase++) begin
            case (phase % 4)
                0, 3: begin
                    mag = (phase % 4 == 0) ? 1.0 : 0.9 + $urandom_range(200) / 1000.0;
                    ang = $urandom_range(65535) * 6.283185307179586 / 65536.0;
                    rr = cptg_pkg::PH_W'(int'(mag * $cos(ang) * 4194304.0));
                    ri = cptg_pkg::PH_W'(int'(mag * $sin(ang) * 4194304.0));
                    ang = $urandom_range(65535) * 6.283185307179586 / 65536.0;
                    sr = cptg_pkg::PH_W'(int'(mag * $cos(ang) * 4194304.0));
                    si = cptg_pkg::PH_W'(int'(mag * $sin(ang) * 4194304.0));
                end
                1: begin
                    rr = cptg_pkg::PH_W'($urandom);
                    ri = cptg_pkg::PH_W'($urandom);
                    sr = cptg_pkg::PH_W'($urandom);
                    si = cptg_pkg::PH_W'($urandom);
                end
                default: begin
                    rr = pick_extreme();
                    ri = pick_extreme();
                    sr = pick_extreme();
                    si = pick_extreme();
                end
            endcase
            program_tone(rr, ri, sr, si);
            no_gaps = (phase == 6);
            send_item(KIND_RESTART, cptg_pkg::SCALE_W'($urandom), $urandom, $urandom);
            for (int n = 0; n < BEATS_PER_TONE; n++) begin
                if ($urandom_range(99) < 8) begin
                    send_item(KIND_RESTART, cptg_pkg::SCALE_W'($urandom), $urandom, $urandom);
                end else begin
                    case ($urandom_range(3))
                        0: scale = 18'sd16384;
                        1: scale = cptg_pkg::SCALE_W'($urandom);
                        default: scale = cptg_pkg::SCALE_W'(int'($urandom_range(32768)) - 16384);
                    endcase
                    case ($urandom_range(3))
                        0: begin
                            acc_re = 32'sd0;
                            acc_im = 32'sd0;
                        end
                        1: begin
                            acc_re = int'($urandom_range(1 << 24)) - (1 << 23);
                            acc_im = int'($urandom_range(1 << 24)) - (1 << 23);
                        end
                        2: begin
                            acc_re = $urandom;
                            acc_im = $urandom;
                        end
                        default: begin
                            // Close to either rail, so the scaled phasor pushes into saturation.
                            acc_re = $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(1 << 26)
                                                       : 32'h80000000 + $urandom_range(1 << 26);
                            acc_im = $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(1 << 26)
                                                       : 32'h80000000 + $urandom_range(1 << 26);
                        end
                    endcase
                    send_item(KIND_SAMPLE, scale, acc_re, acc_im);
                end
            end
            no_gaps = 1'b0;
            drain_and_settle();
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_sample = m_tdata;
            if (expected_samples.size() == 0) begin
                $display("%0t unexpected sample: actual re=%0d im=%0d",
                         $time, got_sample.re, got_sample.im);
                errors++;
            end else begin
                want_sample = expected_samples.pop_front();
                if (got_sample.re !== want_sample.re) begin
                    $display("%0t sample_real mismatch: expected %0d, actual %0d",
                             $time, want_sample.re, got_sample.re);
                    errors++;
                end
                if (got_sample.im !== want_sample.im) begin
                    $display("%0t sample_imag mismatch: expected %0d, actual %0d",
                             $time, want_sample.im, got_sample.im);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_complex_phasor_tone_generator failed");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= KIND_SAMPLE;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= cptg_pkg::REG_RATE_REAL;
        cfg_wdata <= '0;
        rate_re  = 4194304;
        rate_im  = 0;
        start_re = 4194304;
        start_im = 0;
        ph_re    = 4194304;
        ph_im    = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sample_extremes();
        test_quarter_turn();
        test_runaway_phasor();
        test_random_tones();

        if (errors == 0) begin
            $display("tb_complex_phasor_tone_generator passed");
        end else begin
            $display("tb_complex_phasor_tone_generator failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cptg_pkg.sv
rtl/core/cptg_front.sv
rtl/core/cptg_back.sv
rtl/core/complex_phasor_tone_generator.sv
sim/tb_complex_phasor_tone_generator.sv
